// ===== rtl/skx_pkg.sv =====
// ----------------------------------------------------------------------------
// skx_pkg
// shared types and constants for the splitmix64 keystream xor cipher
// ----------------------------------------------------------------------------
package skx_pkg;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int unsigned SHIFT_1    = 30;
  localparam int unsigned SHIFT_2    = 27;
  localparam int unsigned SHIFT_3    = 31;

  // input transaction
  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_of_message;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] plain_byte;
    logic [7:0] key_byte;
    logic       last_out;
  } out_t;

  // classified byte, front to back
  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last;
    logic       load_seed;
    logic       new_word;
    logic [2:0] pos;
  } job_t;

  // back to mixer
  typedef struct packed {
    logic start;
    logic load_seed;
  } mix_req_t;

  // mixer to back
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] word;
  } mix_rsp_t;

  typedef enum logic [2:0] {
    MIX_IDLE,
    MIX_MLO,
    MIX_MH1,
    MIX_MH2,
    MIX_XS,
    MIX_FIN
  } mix_state_e;

endpackage

// ===== rtl/skx_front.sv =====
// ----------------------------------------------------------------------------
// skx_front
// accepts bytes and tags them with message start, word start and position
// ----------------------------------------------------------------------------
module skx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  skx_pkg::in_t   in_data_i,
  output logic           in_ready_o,
  input  logic           q_full_i,
  output logic           push_o,
  output skx_pkg::job_t  job_o
);
  import skx_pkg::*;

  logic       msg_start_q, msg_start_d;
  logic [2:0] pos_q, pos_d;

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    job_o.cipher_byte = in_data_i.cipher_byte;
    job_o.last        = in_data_i.last_of_message;
    job_o.load_seed   = msg_start_q;
    job_o.pos         = msg_start_q ? 3'd0 : pos_q;
    job_o.new_word    = msg_start_q | (pos_q == 3'd0);
    pos_d             = pos_q;
    msg_start_d       = msg_start_q;
    if (push_o) begin
      pos_d       = job_o.pos + 3'd1;
      msg_start_d = in_data_i.last_of_message;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_start_q <= 1'b1;
      pos_q       <= 3'd0;
    end else begin
      msg_start_q <= msg_start_d;
      pos_q       <= pos_d;
    end
  end

endmodule

// ===== rtl/skx_queue.sv =====
// ----------------------------------------------------------------------------
// skx_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module skx_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  skx_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output skx_pkg::job_t  head_o
);
  import skx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/skx_mixer.sv =====
// ----------------------------------------------------------------------------
// skx_mixer
// splitmix64 generator: advance, then two 64-bit multiplies on one 32x32 unit
// ----------------------------------------------------------------------------
module skx_mixer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       seed_i,
  input  skx_pkg::mix_req_t req_i,
  output skx_pkg::mix_rsp_t rsp_o
);
  import skx_pkg::*;

  mix_state_e  state_q, state_d;
  logic        round_q;
  logic [63:0] gen_q;
  logic [63:0] x_q;
  logic [63:0] acc_q;
  logic [63:0] adv;
  logic [63:0] cst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  assign adv  = (req_i.load_seed ? seed_i : gen_q) + GOLDEN_INC;
  assign cst  = round_q ? MIX_MUL_B : MIX_MUL_A;
  assign prod = 64'(mul_a) * 64'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MIX_IDLE: if (req_i.start) state_d = MIX_MLO;
      MIX_MLO:  state_d = MIX_MH1;
      MIX_MH1:  state_d = MIX_MH2;
      MIX_MH2:  state_d = round_q ? MIX_FIN : MIX_XS;
      MIX_XS:   state_d = MIX_MLO;
      MIX_FIN:  state_d = MIX_IDLE;
      default:  state_d = MIX_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    mul_a      = x_q[31:0];
    mul_b      = cst[31:0];
    rsp_o.busy = (state_q != MIX_IDLE);
    rsp_o.done = 1'b0;
    rsp_o.word = acc_q ^ (acc_q >> SHIFT_3);
    case (state_q)
      MIX_MH1: mul_b = cst[63:32];
      MIX_MH2: mul_a = x_q[63:32];
      MIX_FIN: rsp_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MIX_IDLE: if (req_i.start) x_q <= adv ^ (adv >> SHIFT_1);
      MIX_MLO:  acc_q <= prod;
      MIX_MH1,
      MIX_MH2:  acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      MIX_XS:   x_q <= acc_q ^ (acc_q >> SHIFT_2);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MIX_IDLE;
      round_q <= 1'b0;
      gen_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MIX_IDLE && req_i.start) begin
        gen_q   <= adv;
        round_q <= 1'b0;
      end else if (state_q == MIX_XS) begin
        round_q <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/skx_back.sv =====
// ----------------------------------------------------------------------------
// skx_back
// draws keystream words, xors bytes and holds the output register
// ----------------------------------------------------------------------------
module skx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  skx_pkg::job_t     head_i,
  output logic              pop_o,
  output skx_pkg::mix_req_t mix_req_o,
  input  skx_pkg::mix_rsp_t mix_rsp_i,
  output logic              out_valid_o,
  output skx_pkg::out_t     out_data_o,
  input  logic              out_ready_i
);
  import skx_pkg::*;

  logic [63:0] key_word_q;
  logic        word_ok_q;
  logic        out_valid_q;
  out_t        out_q;
  logic [7:0]  kb;
  logic        have_key;

  assign have_key = ~head_i.new_word | word_ok_q;
  assign kb       = key_word_q[{head_i.pos, 3'b000} +: 8];

  assign mix_req_o.start     = head_valid_i & head_i.new_word & ~word_ok_q & ~mix_rsp_i.busy;
  assign mix_req_o.load_seed = head_i.load_seed;

  assign pop_o       = head_valid_i & have_key & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mix_rsp_i.done) begin
      key_word_q <= mix_rsp_i.word;
    end
    if (pop_o) begin
      out_q.plain_byte <= head_i.cipher_byte ^ kb;
      out_q.key_byte   <= kb;
      out_q.last_out   <= head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mix_rsp_i.done) begin
        word_ok_q <= 1'b1;
      end else if (pop_o) begin
        word_ok_q <= 1'b0;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/splitmix_keystream_xor.sv =====
// timing: a byte that opens a keystream word waits at the queue head while the mixer draws
//   the word on the shared 32x32 multiplier; other bytes go from the queue head to the output register
// throughput: set by the mixer, drawing one word per 8 bytes when a word-opening byte heads
//   the queue; the 7 bytes that reuse a word pass at one per cycle unless the output stalls
// reset: async active low; seed 0, generator state 0, next byte starts a message
// ----------------------------------------------------------------------------
// splitmix_keystream_xor
// byte stream cipher xoring data with a splitmix64 keystream
// ----------------------------------------------------------------------------
module splitmix_keystream_xor #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration: seed register
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  // input transactions
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skx_pkg::in_t  in_data_i,
  // output transactions
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skx_pkg::out_t out_data_o
);
  import skx_pkg::*;

  // seed, sampled by the mixer when a message starts
  logic [63:0] seed_q;

  // front to queue
  logic        push;
  job_t        job_in;
  logic        q_full;

  // queue to back
  logic        q_valid;
  logic        pop;
  job_t        head;

  // back to mixer
  mix_req_t    mix_req;
  mix_rsp_t    mix_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // front: tags each transaction with message start, word start and byte position
  skx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // decouples the front from the mixer stalls
  skx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // keystream word generator, one word per request
  skx_mixer u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_q),
    .req_i  (mix_req),
    .rsp_o  (mix_rsp)
  );

  // back: waits for the word where needed, xors, drives the output register
  skx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .mix_req_o    (mix_req),
    .mix_rsp_i    (mix_rsp),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
